@@ rtl/core/gsp_pkg.sv @@
// ----------------------------------------------------------------------------
// gsp_pkg: shared types and constants of the gripper position model
// Beat formats, state record, op and command codes, fixed-point limits.
// ----------------------------------------------------------------------------
package gsp_pkg;

    // Op codes of an input beat
    localparam logic [1:0] OP_REG  = 2'd0;
    localparam logic [1:0] OP_SVC  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Service command types
    localparam logic [2:0] CMD_POS     = 3'd0;
    localparam logic [2:0] CMD_SPEED   = 3'd1;
    localparam logic [2:0] CMD_FORCE   = 3'd2;
    localparam logic [2:0] CMD_ACT     = 3'd3;
    localparam logic [2:0] CMD_DEACT   = 3'd4;
    localparam logic [2:0] CMD_RELEASE = 3'd5;
    localparam logic [2:0] CMD_STOP    = 3'd6;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_INACT   = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN = 2'd2;

    // Object status codes
    localparam logic [1:0] OBJ_NONE   = 2'd0;
    localparam logic [1:0] OBJ_HELD   = 2'd1;
    localparam logic [1:0] OBJ_OPEN   = 2'd2;
    localparam logic [1:0] OBJ_CLOSED = 2'd3;

    // Fixed-point limits, full scale 65535 = fully closed
    localparam logic [15:0] DEAD_BAND     = 16'd65;
    localparam logic [15:0] OBJ_THRESHOLD = 16'd45874;
    localparam logic [15:0] CLOSED_LIMIT  = 16'd64880;
    localparam logic [15:0] OPEN_LIMIT    = 16'd655;
    localparam logic [7:0]  IDLE_CURRENT  = 8'd25;
    localparam logic [10:0] MOVE_BASE     = 11'd765;
    localparam logic [10:0] HOLD_BASE     = 11'd1530;
    localparam logic [7:0]  RESET_LEVEL   = 8'd128;
    localparam logic [7:0]  FULL_SPEED    = 8'd255;

    typedef struct packed {
        logic [1:0] op;
        logic       act_bit;
        logic       go_bit;
        logic [7:0] pos_request;
        logic [7:0] speed_request;
        logic [7:0] force_request;
        logic [2:0] svc_type;
        logic [7:0] command_value;
        logic [9:0] elapsed;
        logic       detect_window;
    } t_gsp_in;

    typedef struct packed {
        logic       success;
        logic [1:0] error_code;
        logic       activated;
        logic       moving;
        logic [1:0] object_status;
        logic [7:0] target_byte;
        logic [7:0] position_byte;
        logic [7:0] current_byte;
    } t_gsp_out;

    typedef struct packed {
        logic [15:0] pos;
        logic [7:0]  target;
        logic [7:0]  speed;
        logic [7:0]  force_lvl;
        logic        active;
        logic        moving;
        logic        obj_seen;
        logic [7:0]  current;
    } t_gsp_state;

    // floor(v / 10) for v below 2048: multiply by 6554 / 2^16
    function automatic logic [7:0] div10(input logic [10:0] v);
        logic [23:0] prod;
        prod = 24'(v) * 24'd6554;
        return prod[23:16];
    endfunction

endpackage

@@ rtl/core/gripper_slew_position_model_top.sv @@
// ----------------------------------------------------------------------------
// gripper_slew_position_model_top: parallel gripper position model
// Takes register commands, service commands and time ticks; keeps the
// gripper state and returns one status beat per input beat.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------
//  in       | input     | i_in_valid / o_in_ready   | i_in_data  (t_gsp_in)
//  out      | output    | o_out_valid / i_out_ready | o_out_data (t_gsp_out)
//
//  Each beat is first held in the input register; the update logic then
//  writes the state and the status register when the beat leaves it, so the
//  status beat is registered in the status register behind the input register.
//  Unless the output stalls, one beat per cycle is sustained, set by the
//  single-pass update between the input and the state/status registers. Reset
//  (synchronous, active low) empties both stages and loads the state reset
//  values. A stalled output holds its beat; the input register takes one more
//  beat and then holds o_in_ready low, so at most two beats are in flight.
// ----------------------------------------------------------------------------
module gripper_slew_position_model_top import gsp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_gsp_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_gsp_out o_out_data
);

    // Stage handshake: the input register moves on whenever the status
    // register is empty or being taken this cycle.
    logic       w_stage_valid;
    t_gsp_in    w_stage_data;
    logic       w_advance;
    logic       w_apply;

    t_gsp_state r_state;
    t_gsp_state n_state;
    t_gsp_out   r_out;
    t_gsp_out   w_result;
    logic       r_out_valid;
    logic       n_out_valid;

    assign w_advance = !r_out_valid || i_out_ready;
    assign w_apply   = w_stage_valid && w_advance;

    gsp_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_advance  (w_advance),
        .o_valid    (w_stage_valid),
        .o_data     (w_stage_data)
    );

    gsp_update u_update (
        .i_item   (w_stage_data),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // Status register valid: fill on apply, drop once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_apply) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Gripper state: commit the update only when the beat leaves the stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid       <= 1'b0;
            r_state.pos       <= '0;
            r_state.target    <= '0;
            r_state.speed     <= RESET_LEVEL;
            r_state.force_lvl <= RESET_LEVEL;
            r_state.active    <= 1'b0;
            r_state.moving    <= 1'b0;
            r_state.obj_seen  <= 1'b0;
            r_state.current   <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_apply) begin
                r_state <= n_state;
            end
        end
    end

    // Status payload: load with the state commit
    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Object flag is sticky until reset
    a_obj_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.obj_seen |=> r_state.obj_seen)
        else $error("object flag cleared without reset");

    // Position moves only from an active, moving state
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_state.active || !r_state.moving) |=> $stable(r_state.pos))
        else $error("position changed while idle or inactive");

    // Success and error code agree
    a_err_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.success == (o_out_data.error_code == ERR_NONE)))
        else $error("success and error code disagree");

    // Inactive gripper reports no object status
    a_inactive_obj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.activated) |-> (o_out_data.object_status == OBJ_NONE))
        else $error("object status reported while inactive");

    // State changes only when a beat is applied
    a_state_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_apply |=> $stable(r_state))
        else $error("state changed without an applied beat");

endmodule

@@ rtl/core/gsp_in_stage.sv @@
// ----------------------------------------------------------------------------
// gsp_in_stage: input register of the gripper model
// Holds one beat until the update stage takes it.
// ----------------------------------------------------------------------------
module gsp_in_stage import gsp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_gsp_in i_in_data,
    input  logic    i_advance,
    output logic    o_valid,
    output t_gsp_in o_data
);

    logic    r_valid;
    logic    n_valid;
    t_gsp_in r_data;
    logic    w_load;

    assign o_in_ready = !r_valid || i_advance;
    assign w_load     = i_in_valid && o_in_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_in_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/core/gsp_update.sv @@
// ----------------------------------------------------------------------------
// gsp_update: next-state and status logic of the gripper model
// Applies one beat to the state and forms its status beat.
// ----------------------------------------------------------------------------
module gsp_update import gsp_pkg::*; (
    input  t_gsp_in    i_item,
    input  t_gsp_state i_state,
    output t_gsp_state o_state,
    output t_gsp_out   o_result
);

    logic [15:0] w_tgt;
    logic        w_up;
    logic [15:0] w_dist;
    logic [17:0] w_prod;
    logic [26:0] w_scaled;
    logic [16:0] w_step_full;
    logic [15:0] w_step;
    logic [15:0] w_pos_slew;
    logic [7:0]  w_cur_move;
    logic [7:0]  w_cur_hold;
    t_gsp_state  n_state;
    logic        w_ok;
    logic [1:0]  w_err;
    logic [1:0]  w_obj;

    // Slew step: floor(speed * elapsed * 257 / 1024), clamped to distance
    assign w_tgt       = {i_state.target, i_state.target};
    assign w_up        = w_tgt > i_state.pos;
    assign w_dist      = w_up ? (w_tgt - i_state.pos) : (i_state.pos - w_tgt);
    assign w_prod      = 18'(i_state.speed) * 18'(i_item.elapsed);
    assign w_scaled    = {9'd0, w_prod} + {1'b0, w_prod, 8'd0};
    assign w_step_full = w_scaled[26:10];
    assign w_step      = (w_step_full > {1'b0, w_dist}) ? w_dist : w_step_full[15:0];
    assign w_pos_slew  = w_up ? (i_state.pos + w_step) : (i_state.pos - w_step);
    assign w_cur_move  = div10(MOVE_BASE + {2'd0, i_state.speed, 1'b0});
    assign w_cur_hold  = div10(HOLD_BASE + {2'd0, i_state.force_lvl, 1'b0});

    always_comb begin
        n_state = i_state;
        w_ok    = 1'b1;
        w_err   = ERR_NONE;
        unique case (i_item.op)
            OP_REG: begin
                n_state.active = i_item.act_bit;
                if (i_item.act_bit && i_item.go_bit) begin
                    n_state.target    = i_item.pos_request;
                    n_state.speed     = i_item.speed_request;
                    n_state.force_lvl = i_item.force_request;
                    n_state.moving    = 1'b1;
                end
            end
            OP_SVC: begin
                if (!i_state.active && i_item.svc_type != CMD_ACT) begin
                    w_ok  = 1'b0;
                    w_err = ERR_INACT;
                end else begin
                    unique case (i_item.svc_type)
                        CMD_POS: begin
                            n_state.target = i_item.command_value;
                            n_state.moving = 1'b1;
                        end
                        CMD_SPEED: n_state.speed = i_item.command_value;
                        CMD_FORCE: n_state.force_lvl = i_item.command_value;
                        CMD_ACT:   n_state.active = 1'b1;
                        CMD_DEACT: begin
                            n_state.active = 1'b0;
                            n_state.moving = 1'b0;
                        end
                        CMD_RELEASE: begin
                            n_state.target = '0;
                            n_state.speed  = FULL_SPEED;
                            n_state.moving = 1'b1;
                        end
                        CMD_STOP: n_state.moving = 1'b0;
                        default: begin
                            w_ok  = 1'b0;
                            w_err = ERR_UNKNOWN;
                        end
                    endcase
                end
            end
            OP_TICK: begin
                if (i_state.active && i_state.moving) begin
                    if (w_dist > DEAD_BAND) begin
                        n_state.pos = w_pos_slew;
                        if (w_up && w_pos_slew > OBJ_THRESHOLD && i_item.detect_window) begin
                            n_state.obj_seen = 1'b1;
                        end
                    end else begin
                        n_state.pos    = w_tgt;
                        n_state.moving = 1'b0;
                    end
                    if (n_state.moving) begin
                        n_state.current = w_cur_move;
                    end else if (n_state.obj_seen) begin
                        n_state.current = w_cur_hold;
                    end else begin
                        n_state.current = IDLE_CURRENT;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        priority if (!n_state.active) begin
            w_obj = OBJ_NONE;
        end else if (n_state.obj_seen) begin
            w_obj = OBJ_HELD;
        end else if (n_state.pos >= CLOSED_LIMIT) begin
            w_obj = OBJ_CLOSED;
        end else if (n_state.pos <= OPEN_LIMIT) begin
            w_obj = OBJ_OPEN;
        end else begin
            w_obj = OBJ_NONE;
        end
    end

    assign o_state                = n_state;
    assign o_result.success       = w_ok;
    assign o_result.error_code    = w_err;
    assign o_result.activated     = n_state.active;
    assign o_result.moving        = n_state.moving;
    assign o_result.object_status = w_obj;
    assign o_result.target_byte   = n_state.target;
    assign o_result.position_byte = n_state.pos[15:8];
    assign o_result.current_byte  = n_state.current;

endmodule
